>>> rtl/core/rbd_pkg.sv
// Shared types and constants of the rotated BRIEF descriptor core.
// Depends on nothing; rbd_sample and the core top import it.
`default_nettype none
package rbd_pkg;
    localparam int RowBits   = 8;
    localparam int ColBits   = 8;
    localparam int MaxRows   = 1 << RowBits;
    localparam int MaxCols   = 1 << ColBits;
    localparam int PixAddrW  = RowBits + ColBits;
    localparam int DescBits  = 256;
    localparam int PairW     = $clog2(DescBits);
    localparam int WordCount = DescBits / 64;
    localparam int WordIdxW  = 2;
    localparam int QShift    = 14;
    localparam int OffW      = 5;
    localparam int TrigW     = 16;
    localparam int ProdW     = OffW + TrigW;
    localparam int SumW      = ProdW + 1;
    localparam int DeltaW    = 9;
    localparam int PosW      = 10;
    localparam int DimW      = 9;
    localparam int PixW      = 16;
    localparam int PatW      = 4 * OffW;

    localparam logic [1:0] OpPixel    = 2'd0;
    localparam logic [1:0] OpPattern  = 2'd1;
    localparam logic [1:0] OpDescribe = 2'd2;

    localparam logic [1:0] RegRows = 2'd0;
    localparam logic [1:0] RegCols = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [RowBits-1:0]      row;
        logic [ColBits-1:0]      col;
        logic signed [TrigW-1:0] sine;
        logic signed [TrigW-1:0] cosine;
    } feature_t;

    typedef struct packed {
        logic [DimW-1:0] rows;
        logic [DimW-1:0] cols;
    } limits_t;
endpackage
`default_nettype wire

>>> rtl/core/rbd_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
`default_nettype none
module rbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/rbd_sample.sv
// Two-stage rotation of one test point: products, then rounding, offset and bounds check.
// Depends on rbd_pkg.
`default_nettype none
module rbd_sample (
    input  wire logic                              clk,
    input  wire logic signed [rbd_pkg::OffW-1:0]   row_off,
    input  wire logic signed [rbd_pkg::OffW-1:0]   col_off,
    input  wire rbd_pkg::feature_t                 feature,
    input  wire rbd_pkg::limits_t                  limits,
    output logic [rbd_pkg::PixAddrW-1:0]           pix_addr,
    output logic                                   inside_img
);
    import rbd_pkg::*;

    logic signed [ProdW-1:0] cs_reg, rc_reg, cc_reg, rs_reg;
    logic signed [SumW-1:0]  dr_sum, dc_sum;
    logic signed [DeltaW-1:0] dr, dc;
    logic signed [PosW-1:0]  pos_r, pos_c;
    logic [DimW-1:0]         rows_lim, cols_lim;

    function automatic logic signed [DeltaW-1:0] round_q(input logic signed [SumW-1:0] v);
        logic [SumW:0] mag;
        logic [SumW:0] q;
        mag = v[SumW-1] ? (SumW+1)'(-$signed({v[SumW-1], v})) : {1'b0, v};
        q = (mag + (SumW+1)'(1 << (QShift - 1))) >> QShift;
        return v[SumW-1] ? -$signed(DeltaW'(q)) : $signed(DeltaW'(q));
    endfunction

    always_ff @(posedge clk)
    begin
        cs_reg <= col_off * feature.sine;
        rc_reg <= row_off * feature.cosine;
        cc_reg <= col_off * feature.cosine;
        rs_reg <= row_off * feature.sine;
    end

    always_comb
    begin
        dr_sum   = SumW'(cs_reg) + SumW'(rc_reg);
        dc_sum   = SumW'(cc_reg) - SumW'(rs_reg);
        dr       = round_q(dr_sum);
        dc       = round_q(dc_sum);
        pos_r    = $signed({{(PosW-RowBits){1'b0}}, feature.row}) + PosW'(dr);
        pos_c    = $signed({{(PosW-ColBits){1'b0}}, feature.col}) + PosW'(dc);
        rows_lim = (limits.rows > DimW'(MaxRows)) ? DimW'(MaxRows) : limits.rows;
        cols_lim = (limits.cols > DimW'(MaxCols)) ? DimW'(MaxCols) : limits.cols;
    end

    always_ff @(posedge clk)
    begin
        pix_addr   <= {pos_r[RowBits-1:0], pos_c[ColBits-1:0]};
        inside_img <= !pos_r[PosW-1] && !pos_c[PosW-1]
                      && (pos_r[PosW-2:0] < rows_lim) && (pos_c[PosW-2:0] < cols_lim);
    end
endmodule
`default_nettype wire

>>> rtl/core/rotated_brief_descriptor_core.sv
// Rotated BRIEF descriptor core: image and pattern stores, pair walker and word output.
// Depends on rbd_pkg, rbd_ram and rbd_sample.
//
// Pixel and pattern loads take one beat each and are accepted every cycle while the core
// is not walking a feature. A describe beat walks the 256 stored pattern pairs, one pair a
// cycle through the pattern memory and two copies of the image memory, so a feature holds
// the input while its pairs pass the pattern read, rotation products, pixel address and
// image read registers. Its descriptor then leaves as four 64-bit beats from a separate
// buffer, while loads and the next feature proceed. A feature that finishes while the
// previous descriptor is still leaving holds the input until the buffer is free.
`default_nettype none
module rotated_brief_descriptor_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // address, pixel_value, first_row_offset, first_col_offset, second_row_offset,
    // second_col_offset, feature_row, feature_col, sine_q14, cosine_q14, zero padding
    input  wire logic [103:0]  s_tdata,
    // operation
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // descriptor_word, word_index, zero padding
    output logic [71:0]        m_tdata,
    output logic               m_tlast,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [8:0]    cfg_data
);
    import rbd_pkg::*;

    state_t state_reg, state_next;
    logic [PairW-1:0] cnt_reg, cnt_next;
    logic [3:0] vld_reg, last_reg;
    logic [1:0] ina_reg;
    feature_t feat_reg;
    limits_t lim_reg;
    logic [DescBits-1:0] desc_reg, emit_reg;
    logic emit_busy_reg;
    logic [WordIdxW-1:0] word_reg;
    logic in_beat, out_beat, issue, load_emit, bit_val;
    logic [PatW-1:0] pat_rdata;
    logic [PixAddrW-1:0] addr_a, addr_b;
    logic in_a, in_b;
    logic [PixW-1:0] pix_a, pix_b, val_a, val_b;
    logic pix_we, pat_we;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign pix_we = in_beat && (s_tuser == OpPixel);
    assign pat_we = in_beat && (s_tuser == OpPattern) && (s_tdata[15:PairW] == '0);

    rbd_ram #(.WIDTH(PatW), .DEPTH(DescBits)) u_pat_ram (
        .clk(clk), .we(pat_we), .waddr(s_tdata[PairW-1:0]), .wdata(s_tdata[51:32]),
        .raddr(cnt_reg), .rdata(pat_rdata)
    );
    rbd_ram #(.WIDTH(PixW), .DEPTH(1 << PixAddrW)) u_img_ram_a (
        .clk(clk), .we(pix_we), .waddr(s_tdata[15:0]), .wdata(s_tdata[31:16]),
        .raddr(addr_a), .rdata(pix_a)
    );
    rbd_ram #(.WIDTH(PixW), .DEPTH(1 << PixAddrW)) u_img_ram_b (
        .clk(clk), .we(pix_we), .waddr(s_tdata[15:0]), .wdata(s_tdata[31:16]),
        .raddr(addr_b), .rdata(pix_b)
    );

    rbd_sample u_sample_a (
        .clk(clk), .row_off(pat_rdata[4:0]), .col_off(pat_rdata[9:5]),
        .feature(feat_reg), .limits(lim_reg), .pix_addr(addr_a), .inside_img(in_a)
    );
    rbd_sample u_sample_b (
        .clk(clk), .row_off(pat_rdata[14:10]), .col_off(pat_rdata[19:15]),
        .feature(feat_reg), .limits(lim_reg), .pix_addr(addr_b), .inside_img(in_b)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        issue      = 1'b0;
        load_emit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (s_tuser == OpDescribe))
                begin
                    state_next = ST_WALK;
                    cnt_next   = '0;
                end
            end
            ST_WALK:
            begin
                issue    = 1'b1;
                cnt_next = cnt_reg + PairW'(1);
                if (cnt_reg == PairW'(DescBits - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (vld_reg[3] && last_reg[3])
                begin
                    if (!emit_busy_reg)
                    begin
                        load_emit  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (!emit_busy_reg)
                begin
                    load_emit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            vld_reg       <= '0;
            last_reg      <= '0;
            emit_busy_reg <= 1'b0;
            word_reg      <= '0;
            lim_reg.rows  <= DimW'(MaxRows);
            lim_reg.cols  <= DimW'(MaxCols);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= {vld_reg[2:0], issue};
            last_reg  <= {last_reg[2:0], issue && (cnt_reg == PairW'(DescBits - 1))};
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == RegRows)
                begin
                    lim_reg.rows <= cfg_data;
                end
                else if (cfg_index == RegCols)
                begin
                    lim_reg.cols <= cfg_data;
                end
            end
            if (load_emit)
            begin
                emit_busy_reg <= 1'b1;
                word_reg      <= '0;
            end
            else if (out_beat)
            begin
                word_reg <= word_reg + WordIdxW'(1);
                if (word_reg == WordIdxW'(WordCount - 1))
                begin
                    emit_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        val_a   = ina_reg[0] ? pix_a : '0;
        val_b   = ina_reg[1] ? pix_b : '0;
        bit_val = (val_a < val_b);
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && (s_tuser == OpDescribe))
        begin
            feat_reg.row    <= s_tdata[59:52];
            feat_reg.col    <= s_tdata[67:60];
            feat_reg.sine   <= s_tdata[83:68];
            feat_reg.cosine <= s_tdata[99:84];
        end
        ina_reg <= {in_b, in_a};
        if (vld_reg[3])
        begin
            desc_reg <= {bit_val, desc_reg[DescBits-1:1]};
        end
        if (load_emit)
        begin
            if (state_reg == ST_HOLD)
            begin
                emit_reg <= desc_reg;
            end
            else
            begin
                emit_reg <= {bit_val, desc_reg[DescBits-1:1]};
            end
        end
        else if (out_beat)
        begin
            emit_reg <= {64'd0, emit_reg[DescBits-1:64]};
        end
    end

    assign m_tvalid = emit_busy_reg;
    assign m_tdata  = {6'd0, word_reg, emit_reg[63:0]};
    assign m_tlast  = (word_reg == WordIdxW'(WordCount - 1));

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_emit |-> !emit_busy_reg)
        else $error("descriptor buffer loaded while still busy");
    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && last_reg[3]) |-> (state_reg == ST_DRAIN))
        else $error("final pair left the pipeline outside the drain state");
    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && m_tlast) |=> !m_tvalid)
        else $error("output still valid after the last word");
    a_no_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg != 4'd0) |-> !s_tready || (state_reg == ST_IDLE && !vld_reg[3]))
        else $error("input taken while pairs were in flight");
endmodule
`default_nettype wire
